[rtl/sorted_id_list_intersection_unit_assert.svh]
// Assertion macros used by the checker file of this block.
`ifndef SORTED_ID_LIST_INTERSECTION_UNIT_ASSERT_SVH
`define SORTED_ID_LIST_INTERSECTION_UNIT_ASSERT_SVH

// Implication checked on every rising clock edge outside reset.
`define SILI_ASSERT_IMPL(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define SILI_ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

[rtl/sili_pkg.sv]
// ------------------------------------------------------------------------
// sili_pkg
// Types and constants shared by the sorted id list intersection unit.
// ------------------------------------------------------------------------
package sili_pkg;

  localparam int MaxIdsDefault = 64;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_CLOSE  = 2'd1,
    OP_FINISH = 2'd2,
    OP_NONE   = 2'd3
  } sili_op_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] row_id;
  } sili_in_t;

  typedef struct packed {
    logic [31:0] result_id;
    logic        last_item;
    logic        set_empty;
    logic        overflowed;
  } sili_out_t;

  // Command handed from the front part to the back part.
  typedef struct packed {
    sili_op_t    op;
    logic [31:0] row_id;
  } sili_cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SORT_RD,
    ST_SORT_CMP,
    ST_SORT_WR,
    ST_COPY_RD,
    ST_COPY_WR,
    ST_MRG_RD,
    ST_MRG_CMP,
    ST_EMIT_RD,
    ST_EMIT_OUT
  } sili_state_t;

endpackage

[rtl/sili_front.sv]
// ------------------------------------------------------------------------
// sili_front
// Accepts input items, drops unused codes and queues commands.
// ------------------------------------------------------------------------
module sili_front #(
  parameter int Depth = 2
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  sili_pkg::sili_in_t  in_data,
  output logic                cmd_valid,
  input  logic                cmd_take,
  output sili_pkg::sili_cmd_t cmd
);
  import sili_pkg::*;

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

  sili_cmd_t      fifo [Depth];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [AW:0]    fill;
  logic           push;
  logic           pop;

  // Items with the unused code are accepted and discarded here.
  assign in_stall  = (fill == (AW+1)'(Depth));
  assign push      = in_valid && !in_stall && (in_data.operation != OP_NONE);
  assign cmd_valid = (fill != '0);
  assign pop       = cmd_valid && cmd_take;
  assign cmd       = fifo[rd_ptr];

  // Queue pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(Depth-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(Depth-1)) ? '0 : rd_ptr + 1'b1;
      end
      fill <= fill + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr].op     <= sili_op_t'(in_data.operation);
      fifo[wr_ptr].row_id <= in_data.row_id;
    end
  end

endmodule

[rtl/sili_back.sv]
// ------------------------------------------------------------------------
// sili_back
// Holds the gather and working stores, sorts, intersects and emits.
// ------------------------------------------------------------------------
module sili_back #(
  parameter int MaxIds = sili_pkg::MaxIdsDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_take,
  input  sili_pkg::sili_cmd_t cmd,
  output logic                out_valid,
  input  logic                out_stall,
  output sili_pkg::sili_out_t out_data
);
  import sili_pkg::*;

  localparam int AW = (MaxIds > 1) ? $clog2(MaxIds) : 1;
  localparam int CW = $clog2(MaxIds + 1);

  // Memories: gather store and working store.
  logic [31:0] gmem [MaxIds];
  logic [31:0] wmem [MaxIds];
  logic [31:0] g_rd;
  logic [31:0] w_rd;
  logic [AW-1:0] g_ra, g_wa, w_ra, w_wa;
  logic          g_we, w_we;
  logic [31:0]   g_wd, w_wd;

  always_ff @(posedge clk) begin
    if (g_we) begin
      gmem[g_wa] <= g_wd;
    end
    g_rd <= gmem[g_ra];
  end

  always_ff @(posedge clk) begin
    if (w_we) begin
      wmem[w_wa] <= w_wd;
    end
    w_rd <= wmem[w_ra];
  end

  sili_state_t state, state_next;
  logic [CW-1:0] gcount, gcount_next;
  logic [CW-1:0] wcount, wcount_next;
  logic          first, first_next;
  logic          ovf, ovf_next;
  logic [CW-1:0] ia, ia_next;       // outer index / merge a / emit index
  logic [CW-1:0] jb, jb_next;       // inner index / merge b
  logic [CW-1:0] kk, kk_next;       // merge output index
  logic [31:0]   key, key_next;     // insertion key
  logic          ovalid, ovalid_next;
  sili_out_t     obuf, obuf_next;

  assign out_valid = ovalid;
  assign out_data  = obuf;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      gcount <= '0;
      wcount <= '0;
      first  <= 1'b1;
      ovf    <= 1'b0;
      ovalid <= 1'b0;
    end else begin
      state  <= state_next;
      gcount <= gcount_next;
      wcount <= wcount_next;
      first  <= first_next;
      ovf    <= ovf_next;
      ovalid <= ovalid_next;
    end
    ia   <= ia_next;
    jb   <= jb_next;
    kk   <= kk_next;
    key  <= key_next;
    obuf <= obuf_next;
  end

  // Sequencer: gathering of added ids, insertion sort of the gather list,
  // then copy or merge, and the emit walk on finish.
  always_comb begin
    state_next  = state;
    gcount_next = gcount;
    wcount_next = wcount;
    first_next  = first;
    ovf_next    = ovf;
    ia_next     = ia;
    jb_next     = jb;
    kk_next     = kk;
    key_next    = key;
    ovalid_next = ovalid;
    obuf_next   = obuf;
    cmd_take    = 1'b0;
    g_ra = '0; g_wa = '0; g_we = 1'b0; g_wd = cmd.row_id;
    w_ra = '0; w_wa = '0; w_we = 1'b0; w_wd = w_rd;

    if (ovalid && !out_stall) begin
      ovalid_next = 1'b0;
    end

    unique case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          unique case (cmd.op)
            OP_ADD: begin
              cmd_take = 1'b1;
              if (gcount < CW'(MaxIds)) begin
                g_we        = 1'b1;
                g_wa        = gcount[AW-1:0];
                gcount_next = gcount + 1'b1;
              end else begin
                ovf_next = 1'b1;
              end
            end
            OP_CLOSE: begin
              cmd_take   = 1'b1;
              ia_next    = CW'(1);
              state_next = ST_SORT_RD;
            end
            OP_FINISH: begin
              if (!ovalid || !out_stall) begin
                cmd_take = 1'b1;
                ia_next  = '0;
                if (first || wcount == '0) begin
                  ovalid_next          = 1'b1;
                  obuf_next.result_id  = '0;
                  obuf_next.last_item  = 1'b1;
                  obuf_next.set_empty  = 1'b1;
                  obuf_next.overflowed = ovf;
                  gcount_next = '0;
                  wcount_next = '0;
                  first_next  = 1'b1;
                  ovf_next    = 1'b0;
                end else begin
                  state_next = ST_EMIT_RD;
                end
              end
            end
            default: cmd_take = 1'b1;
          endcase
        end
      end

      // Start of one outer step: read key gather[ia].
      ST_SORT_RD: begin
        if (ia >= gcount) begin
          ia_next = '0;
          jb_next = '0;
          kk_next = '0;
          state_next = first ? ST_COPY_RD : ST_MRG_RD;
        end else begin
          g_ra       = ia[AW-1:0];
          jb_next    = ia;
          state_next = ST_SORT_CMP;
        end
      end

      // Read gather[jb-1] to compare against the key.
      ST_SORT_CMP: begin
        if (jb == ia) begin
          key_next = g_rd;
        end
        if (jb == '0) begin
          g_we       = 1'b1;
          g_wa       = '0;
          g_wd       = (jb == ia) ? g_rd : key;
          ia_next    = ia + 1'b1;
          state_next = ST_SORT_RD;
        end else begin
          g_ra       = AW'(jb - 1'b1);
          state_next = ST_SORT_WR;
        end
      end

      // Shift the larger entry up or place the key.
      ST_SORT_WR: begin
        g_we = 1'b1;
        g_wa = jb[AW-1:0];
        if (g_rd > key) begin
          g_wd       = g_rd;
          jb_next    = jb - 1'b1;
          state_next = ST_SORT_CMP;
        end else begin
          g_wd       = key;
          ia_next    = ia + 1'b1;
          state_next = ST_SORT_RD;
        end
      end

      // First list: copy the sorted gather store into the working store.
      ST_COPY_RD: begin
        if (ia >= gcount) begin
          wcount_next = gcount;
          gcount_next = '0;
          first_next  = 1'b0;
          state_next  = ST_IDLE;
        end else begin
          g_ra       = ia[AW-1:0];
          state_next = ST_COPY_WR;
        end
      end

      ST_COPY_WR: begin
        w_we       = 1'b1;
        w_wa       = ia[AW-1:0];
        w_wd       = g_rd;
        ia_next    = ia + 1'b1;
        state_next = ST_COPY_RD;
      end

      // Merge intersection; kept ids are written back at index kk <= ia.
      ST_MRG_RD: begin
        if (ia >= wcount || jb >= gcount) begin
          wcount_next = kk;
          gcount_next = '0;
          state_next  = ST_IDLE;
        end else begin
          w_ra       = ia[AW-1:0];
          g_ra       = jb[AW-1:0];
          state_next = ST_MRG_CMP;
        end
      end

      ST_MRG_CMP: begin
        priority if (w_rd < g_rd) begin
          ia_next = ia + 1'b1;
        end else if (w_rd > g_rd) begin
          jb_next = jb + 1'b1;
        end else begin
          w_we    = 1'b1;
          w_wa    = kk[AW-1:0];
          w_wd    = w_rd;
          kk_next = kk + 1'b1;
          ia_next = ia + 1'b1;
          jb_next = jb + 1'b1;
        end
        state_next = ST_MRG_RD;
      end

      // Emit walk over the working store.
      ST_EMIT_RD: begin
        w_ra       = ia[AW-1:0];
        state_next = ST_EMIT_OUT;
      end

      // Keep the read address on the current entry while the output waits.
      ST_EMIT_OUT: begin
        w_ra = ia[AW-1:0];
        if (!ovalid || !out_stall) begin
          ovalid_next          = 1'b1;
          obuf_next.result_id  = w_rd;
          obuf_next.last_item  = (ia + 1'b1 == wcount);
          obuf_next.set_empty  = 1'b0;
          obuf_next.overflowed = ovf;
          ia_next              = ia + 1'b1;
          if (ia + 1'b1 == wcount) begin
            gcount_next = '0;
            wcount_next = '0;
            first_next  = 1'b1;
            ovf_next    = 1'b0;
            state_next  = ST_IDLE;
          end else begin
            state_next = ST_EMIT_RD;
          end
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

endmodule

[rtl/sorted_id_list_intersection_unit.sv]
// ------------------------------------------------------------------------
// Sorted id list intersection unit
// Intersects lists of row ids and emits the surviving ids in order.
// ------------------------------------------------------------------------
// An add item is taken directly while the back part is idle, so ids
// stream at one per cycle through the two-entry command queue. A
// close item sorts the gathered list by insertion through one read
// port of the gather memory, then copies or merges with the working
// set, each step a read state and then a write or compare state. A
// finish item emits the result items in turn, each read from the
// working memory by a registered read and held while the output stalls.
module sorted_id_list_intersection_unit #(
  parameter int MaxIds = sili_pkg::MaxIdsDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  sili_pkg::sili_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output sili_pkg::sili_out_t out_data
);
  import sili_pkg::*;

  sili_cmd_t cmd;
  logic      cmd_valid;
  logic      cmd_take;

  // Front part: intake and command queue.
  sili_front #(.Depth(2)) u_front (
    .clk, .rst, .in_valid, .in_stall, .in_data,
    .cmd_valid, .cmd_take, .cmd
  );

  // Back part: stores and sequencer.
  sili_back #(.MaxIds(MaxIds)) u_back (
    .clk, .rst, .cmd_valid, .cmd_take, .cmd,
    .out_valid, .out_stall, .out_data
  );

endmodule

[rtl/sili_checker.sv]
// ------------------------------------------------------------------------
// sili_checker
// Port-level checks of the intersection unit.
// ------------------------------------------------------------------------
`include "sorted_id_list_intersection_unit_assert.svh"

module sili_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input sili_pkg::sili_in_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input sili_pkg::sili_out_t out_data
);
  import sili_pkg::*;

  // A stalled result item holds.
  `SILI_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall,
    out_valid && $stable(out_data))
  // An empty result is always the final item.
  `SILI_ASSERT_IMPL(a_empty_last, clk, rst, out_valid && out_data.set_empty,
    out_data.last_item)
  // Ids within one query come out in non-descending order.
  `SILI_ASSERT_NEXT(a_ascending, clk, rst,
    out_valid && !out_stall && !out_data.last_item,
    !out_valid || out_data.result_id >= $past(out_data.result_id))
  // The overflow flag is the same on every item of a query.
  `SILI_ASSERT_NEXT(a_ovf_same, clk, rst,
    out_valid && !out_stall && !out_data.last_item,
    !out_valid || out_data.overflowed == $past(out_data.overflowed))

endmodule

bind sorted_id_list_intersection_unit sili_checker u_sili_checker (
  .clk, .rst, .in_valid, .in_stall, .in_data,
  .out_valid, .out_stall, .out_data
);
